FILE: rtl/sync_framed_packet_deframer_assert.svh
// Assertion macros shared by the deframer RTL.
// Users must have clk and rst_n (synchronous, active low) in scope.
`ifndef SYNC_FRAMED_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_FRAMED_PACKET_DEFRAMER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define SFPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define SFPD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

FILE: rtl/sfpd_pkg.sv
// Shared types and constants for the framed packet deframer.
// No dependencies; compiled before all other deframer files.
package sfpd_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int CMP_W           = 9;   // byte plus one bit, for L+1 / L+2 compares
  localparam int IDX_W           = 6;
  localparam int TOT_W           = 16;

  localparam logic [7:0] SYNC_BYTE = 8'hA5;
  localparam logic [7:0] END_BYTE  = 8'h5A;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_DATA  = 2'd1,
    EV_CKSUM = 2'd2,
    EV_OVFL  = 2'd3
  } event_t;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_LENGTH,
    ST_PAYLOAD,
    ST_END1,
    ST_END2,
    ST_SUM_RD,
    ST_SUM_CHK,
    ST_EMIT_RD,
    ST_EMIT_PUT,
    ST_EV_OVFL,
    ST_EV_CKSUM
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic   restart;
    logic   len_load;
    logic   pay_store;
    logic   sum_init;
    logic   sum_acc;
    logic   emit_init;
    logic   good_inc;
    logic   bad_inc;
    logic   out_load;
    event_t out_ev;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sync;
    logic is_end;
    logic sync_seen;
    logic end_seen;
    logic len_big;
    logic store_full;
    logic cnt_hit;
    logic idx_at_chk;
    logic idx_at_last;
    logic sum_ok;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/sfpd_if.sv
// Valid/ready channel interfaces for the deframer's byte input and result output.
// No dependencies.
interface sfpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  data_byte;
  logic [5:0]  byte_index;
  logic        last;
  logic [15:0] good_frames;
  logic [15:0] bad_frames;

  modport source (output valid, output event_res, output data_byte, output byte_index,
                  output last, output good_frames, output bad_frames, input ready);
  modport sink   (input valid, input event_res, input data_byte, input byte_index,
                  input last, input good_frames, input bad_frames, output ready);
endinterface

FILE: rtl/sfpd_ctrl.sv
// Deframer controller: frame phase state machine and checksum/emit sequencer.
// Depends on sfpd_pkg.
module sfpd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfpd_pkg::dp_stat_t stat,
  output sfpd_pkg::dp_cmd_t  cmd
);
  import sfpd_pkg::*;

  state_t state_r, state_nxt;
  logic   acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_HUNT: begin
        if (acc && stat.is_sync) state_nxt = ST_SYNC2;
      end
      ST_SYNC2: begin
        if (acc) state_nxt = stat.is_sync ? ST_LENGTH : ST_HUNT;
      end
      ST_LENGTH: begin
        if (acc) state_nxt = stat.len_big ? ST_EV_OVFL : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        if (acc) begin
          priority if (stat.is_end && stat.end_seen) state_nxt = ST_HUNT;
          else if (stat.store_full)                  state_nxt = ST_EV_OVFL;
          else if (stat.cnt_hit)                     state_nxt = ST_END1;
          else if (stat.is_sync && stat.sync_seen)   state_nxt = ST_LENGTH;
          else                                       state_nxt = ST_PAYLOAD;
        end
      end
      ST_END1: begin
        if (acc) begin
          priority if (stat.is_end) state_nxt = ST_END2;
          else if (stat.is_sync)    state_nxt = ST_SYNC2;
          else                      state_nxt = ST_HUNT;
        end
      end
      ST_END2: begin
        if (acc) begin
          priority if (stat.is_end) state_nxt = ST_SUM_RD;
          else if (stat.is_sync)    state_nxt = ST_SYNC2;
          else                      state_nxt = ST_HUNT;
        end
      end
      ST_SUM_RD:  state_nxt = ST_SUM_CHK;
      ST_SUM_CHK: begin
        if (stat.idx_at_chk) state_nxt = stat.sum_ok ? ST_EMIT_RD : ST_EV_CKSUM;
        else                 state_nxt = ST_SUM_RD;
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_PUT;
      ST_EMIT_PUT: begin
        if (stat.out_free) state_nxt = stat.idx_at_last ? ST_HUNT : ST_EMIT_RD;
      end
      ST_EV_OVFL, ST_EV_CKSUM: begin
        if (stat.out_free) state_nxt = ST_HUNT;
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.out_ev = EV_NONE;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_HUNT: in_ready = 1'b1;
      ST_SYNC2: begin
        in_ready = 1'b1;
        if (acc && !stat.is_sync) cmd.restart = 1'b1;
      end
      ST_LENGTH: begin
        in_ready = 1'b1;
        if (acc) begin
          cmd.len_load = 1'b1;
          cmd.restart  = stat.len_big;
        end
      end
      ST_PAYLOAD: begin
        in_ready = 1'b1;
        if (acc) begin
          if ((stat.is_end && stat.end_seen) || stat.store_full) cmd.restart = 1'b1;
          else cmd.pay_store = 1'b1;
        end
      end
      ST_END1: begin
        in_ready = 1'b1;
        if (acc && !stat.is_end) cmd.restart = 1'b1;
      end
      ST_END2: begin
        in_ready = 1'b1;
        if (acc) begin
          cmd.restart  = 1'b1;
          cmd.sum_init = stat.is_end;
        end
      end
      ST_SUM_RD: ;
      ST_SUM_CHK: begin
        if (stat.idx_at_chk) begin
          cmd.good_inc  = stat.sum_ok;
          cmd.emit_init = stat.sum_ok;
          cmd.bad_inc   = !stat.sum_ok;
        end else begin
          cmd.sum_acc = 1'b1;
        end
      end
      ST_EMIT_RD: ;
      ST_EMIT_PUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ev   = EV_DATA;
        end
      end
      ST_EV_OVFL: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ev   = EV_OVFL;
        end
      end
      ST_EV_CKSUM: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ev   = EV_CKSUM;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/sfpd_dp.sv
// Deframer datapath: frame store, counters, checksum accumulator, result register.
// Depends on sfpd_pkg and sync_framed_packet_deframer_assert.svh.
module sfpd_dp #(
  parameter int STORE_DEPTH = sfpd_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfpd_pkg::dp_cmd_t  cmd,
  input  logic [7:0]         in_byte,
  input  logic               out_ready,
  output sfpd_pkg::dp_stat_t stat,
  output logic               out_valid,
  output logic [1:0]         out_event,
  output logic [7:0]         out_data,
  output logic [5:0]         out_index,
  output logic               out_last,
  output logic [15:0]        out_good,
  output logic [15:0]        out_bad
);
  import sfpd_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic [7:0]       store_mem [STORE_DEPTH];
  logic [7:0]       rdata_r;
  logic [CW-1:0]    count_r;
  logic [7:0]       len_r;
  logic             sync_seen_r;
  logic             end_seen_r;
  logic [AW-1:0]    idx_r;
  logic [7:0]       sum_r;
  logic [TOT_W-1:0] good_r;
  logic [TOT_W-1:0] bad_r;
  logic             out_valid_r;
  event_t           out_ev_r;
  logic [7:0]       out_data_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_last_r;
  logic [TOT_W-1:0] out_good_r;
  logic [TOT_W-1:0] out_bad_r;

  // status
  always_comb begin
    stat.is_sync     = (in_byte == SYNC_BYTE);
    stat.is_end      = (in_byte == END_BYTE);
    stat.sync_seen   = sync_seen_r;
    stat.end_seen    = end_seen_r;
    stat.len_big     = CMP_W'(in_byte) > CMP_W'(STORE_DEPTH - 2);
    stat.store_full  = (count_r >= CW'(STORE_DEPTH));
    // count after this store equals L+2
    stat.cnt_hit     = (CMP_W'(count_r) == CMP_W'(len_r) + CMP_W'(1));
    stat.idx_at_chk  = (CMP_W'(idx_r) == CMP_W'(len_r) + CMP_W'(1));
    stat.idx_at_last = (CMP_W'(idx_r) == CMP_W'(len_r));
    stat.sum_ok      = (sum_r == rdata_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      len_r       <= '0;
      sync_seen_r <= 1'b0;
      end_seen_r  <= 1'b0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.restart) begin
        count_r     <= '0;
        sync_seen_r <= 1'b0;
        end_seen_r  <= 1'b0;
      end else if (cmd.pay_store) begin
        count_r     <= count_r + 1'b1;
        sync_seen_r <= stat.is_sync;
        end_seen_r  <= stat.is_end;
      end else if (cmd.len_load) begin
        if (stat.is_sync)     sync_seen_r <= 1'b1;
        else if (stat.is_end) end_seen_r  <= 1'b1;
      end
      if (cmd.len_load) len_r <= in_byte;
      if (cmd.good_inc) good_r <= good_r + 1'b1;
      if (cmd.bad_inc)  bad_r  <= bad_r + 1'b1;
      if (cmd.out_load)      out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.pay_store) store_mem[count_r[AW-1:0]] <= in_byte;
    rdata_r <= store_mem[idx_r];
  end

  // walk index and checksum
  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      idx_r <= AW'(1);
      sum_r <= '0;
    end else if (cmd.sum_acc) begin
      idx_r <= idx_r + 1'b1;
      sum_r <= sum_r + rdata_r;
    end else if (cmd.emit_init) begin
      idx_r <= '0;
    end else if (cmd.out_load && cmd.out_ev == EV_DATA) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ev_r <= cmd.out_ev;
      if (cmd.out_ev == EV_DATA) begin
        out_data_r  <= rdata_r;
        out_index_r <= IDX_W'(idx_r);
        out_last_r  <= stat.idx_at_last;
      end else begin
        out_data_r  <= '0;
        out_index_r <= '0;
        out_last_r  <= 1'b1;
      end
      out_good_r <= good_r;
      out_bad_r  <= bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_event = out_ev_r;
  assign out_data  = out_data_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;
  assign out_good  = out_good_r;
  assign out_bad   = out_bad_r;

`include "sync_framed_packet_deframer_assert.svh"

  `SFPD_ASSERT(a_store_in_range, cmd.pay_store |-> (count_r < CW'(STORE_DEPTH)), "store write past end")
  `SFPD_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_r || out_ready), "pending result overwritten")
  `SFPD_ASSERT_NEVER(a_one_verdict, cmd.good_inc && cmd.bad_inc, "frame counted good and bad")
  `SFPD_ASSERT(a_load_valid, cmd.out_load |=> out_valid_r, "loaded result not presented")

endmodule

FILE: rtl/sync_framed_packet_deframer.sv
// Top level of the synchronous framed packet deframer.
// Depends on sfpd_pkg, sfpd_if, sfpd_ctrl and sfpd_dp.
//
// Takes received bytes one word at a time and recovers frames of the form
// A5 A5, length L, L+2 stored bytes, 5A 5A. Inside the payload two A5 bytes
// in a row return to the length phase (the count is kept) and two 5A bytes
// in a row abort the frame. On the closing 5A the stored bytes 1..L are
// summed mod 256 and compared with stored byte L+1: a match emits stored
// bytes 0..L as a run of event-1 words with last on the final one, a
// mismatch emits one event-2 word. A length above STORE_DEPTH-2, or a byte
// arriving with the store full, emits one event-3 word. Every result word
// carries the good and bad frame totals after the update.
// Timing: a byte that only advances the frame phase is taken as soon as it
// is offered. A byte that causes an overflow event is taken, then the input
// holds off while the word is loaded (longer if the result register is still
// full). The closing 5A starts a walk over the single read port of the frame
// store: stored bytes 1..L+1 are read in turn for the checksum, then each
// emitted byte is read and put (L+1 words for a good frame, one for a bad
// one), stretched by any output backpressure. The input is held off for the
// whole walk. The result register lets the next frame start while the last
// word of the previous one waits to be taken. No clearing pass after reset.
module sync_framed_packet_deframer #(
  parameter int STORE_DEPTH = sfpd_pkg::STORE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  sfpd_in_if.sink        in_ch,
  sfpd_out_if.source     out_ch
);
  import sfpd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // frame phase and walk sequencing
  sfpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, counters, checksum and the result register
  sfpd_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_byte   (in_ch.rx_byte),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_event (out_ch.event_res),
    .out_data  (out_ch.data_byte),
    .out_index (out_ch.byte_index),
    .out_last  (out_ch.last),
    .out_good  (out_ch.good_frames),
    .out_bad   (out_ch.bad_frames)
  );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for sync_framed_packet_deframer: directed frames, then random
// framed traffic with idling and backpressure, checked word by word against a predictor.
// Depends on sfpd_pkg, sfpd_if and the deframer RTL.
`timescale 1ns / 100ps

module tb;
  import sfpd_pkg::*;

  localparam int DEPTH        = STORE_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 300;   // covers a full checksum walk after the last word
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off for the fill test

  // Frame tracker phases, mirroring the deframer's byte-level state.
  typedef enum logic [2:0] {
    P_HUNT, P_SYNC2, P_LENGTH, P_PAYLOAD, P_END1, P_END2
  } frame_phase_t;

  // How a generated frame is closed.
  typedef enum logic [1:0] {
    CLOSE_OK, CLOSE_BAD_FIRST, CLOSE_BAD_SECOND
  } close_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    logic [5:0]  idx;
    logic        last;
    logic [15:0] good;
    logic [15:0] bad;
  } frame_result_t;

  logic clk;
  logic rst_n;

  sfpd_in_if  in_ch ();
  sfpd_out_if out_ch ();

  sync_framed_packet_deframer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: our own copy of the deframer's frame tracking.
  frame_phase_t  phase      = P_HUNT;
  int            stored_cnt = 0;
  int            frame_len  = 0;
  bit            sync_seen  = 1'b0;
  bit            end_seen   = 1'b0;
  logic [7:0]    store_copy [DEPTH];
  logic [15:0]   good_cnt   = '0;
  logic [15:0]   bad_cnt    = '0;

  frame_result_t expected_words [$];   // words still owed by the block, oldest first
  logic [7:0]    frame_buf [$];        // bytes staged for the next send

  int n_errors        = 0;
  int n_sent          = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_left       = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic restart_frame(input frame_phase_t p);
    phase      = p;
    stored_cnt = 0;
    sync_seen  = 1'b0;
    end_seen   = 1'b0;
  endtask

  // Totals on every word reflect the update made by the byte that caused it.
  task automatic expect_word(input event_t ev, input logic [7:0] d, input int idx,
                             input bit last);
    frame_result_t r;
    r.ev   = ev;
    r.data = d;
    r.idx  = idx[5:0];
    r.last = last;
    r.good = good_cnt;
    r.bad  = bad_cnt;
    expected_words.push_back(r);
  endtask

  // Advance the frame tracker by one accepted byte, queueing the words it causes.
  task automatic track_byte(input logic [7:0] b);
    logic [7:0] sum;
    case (phase)
      P_HUNT: begin
        if (b == SYNC_BYTE) phase = P_SYNC2;
      end
      P_SYNC2: begin
        if (b == SYNC_BYTE) phase = P_LENGTH;
        else restart_frame(P_HUNT);
      end
      P_LENGTH: begin
        // a marker byte as the length counts as the first of a pair
        if (b == SYNC_BYTE) sync_seen = 1'b1;
        else if (b == END_BYTE) end_seen = 1'b1;
        frame_len = int'(b);
        if (frame_len > DEPTH - 2) begin
          restart_frame(P_HUNT);
          expect_word(EV_OVFL, 8'h00, 0, 1'b1);
        end else begin
          phase = P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        // paired A5 goes back to the length phase but the byte is still stored
        if (b == SYNC_BYTE) begin
          if (sync_seen) phase = P_LENGTH;
          else sync_seen = 1'b1;
        end else begin
          sync_seen = 1'b0;
        end
        if (b == END_BYTE && end_seen) begin
          restart_frame(P_HUNT);           // paired 5A aborts silently
        end else begin
          end_seen = (b == END_BYTE);
          if (stored_cnt >= DEPTH) begin
            restart_frame(P_HUNT);
            expect_word(EV_OVFL, 8'h00, 0, 1'b1);
          end else begin
            store_copy[stored_cnt] = b;
            stored_cnt++;
            if (stored_cnt == frame_len + 2) phase = P_END1;
          end
        end
      end
      P_END1: begin
        if (b == END_BYTE) phase = P_END2;
        else restart_frame(b == SYNC_BYTE ? P_SYNC2 : P_HUNT);
      end
      P_END2: begin
        if (b != END_BYTE) begin
          restart_frame(b == SYNC_BYTE ? P_SYNC2 : P_HUNT);
        end else begin
          sum = 8'h00;
          for (int i = 1; i <= frame_len; i++) sum = sum + store_copy[i];
          restart_frame(P_HUNT);
          if (sum != store_copy[frame_len + 1]) begin
            bad_cnt = bad_cnt + 16'd1;
            expect_word(EV_CKSUM, 8'h00, 0, 1'b1);
          end else begin
            good_cnt = good_cnt + 16'd1;
            for (int i = 0; i <= frame_len; i++)
              expect_word(EV_DATA, store_copy[i], i, i == frame_len);
          end
        end
      end
      default: restart_frame(P_HUNT);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every word taken is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_words
    frame_result_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: event_res %0d data_byte %0h", out_ch.event_res,
               out_ch.data_byte);
        n_errors++;
      end else begin
        r = expected_words.pop_front();
        if (out_ch.event_res !== r.ev) begin
          $error("event_res: expected %0d, got %0d", r.ev, out_ch.event_res);
          n_errors++;
        end
        if (out_ch.data_byte !== r.data) begin
          $error("data_byte: expected %0h, got %0h", r.data, out_ch.data_byte);
          n_errors++;
        end
        if (out_ch.byte_index !== r.idx) begin
          $error("byte_index: expected %0d, got %0d", r.idx, out_ch.byte_index);
          n_errors++;
        end
        if (out_ch.last !== r.last) begin
          $error("last: expected %0d, got %0d", r.last, out_ch.last);
          n_errors++;
        end
        if (out_ch.good_frames !== r.good) begin
          $error("good_frames: expected %0d, got %0d", r.good, out_ch.good_frames);
          n_errors++;
        end
        if (out_ch.bad_frames !== r.bad) begin
          $error("bad_frames: expected %0d, got %0d", r.bad, out_ch.bad_frames);
          n_errors++;
        end
      end
    end
  end

  // Receiver side: random stalls, or a forced hold-off counted down here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Offer one word; the predictor sees it at the edge where it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    track_byte(b);
    n_sent++;
  endtask

  task automatic send_buf();
    foreach (frame_buf[i]) send_byte(frame_buf[i]);
    frame_buf.delete();
  endtask

  // Sender stops and waits until every owed word has been taken.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Any byte that cannot act as a marker.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == SYNC_BYTE || b == END_BYTE);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(3))
      0:       return SYNC_BYTE;
      1:       return END_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Well-formed frame with random content; checksum optionally spoiled,
  // closing optionally broken (stray byte is A5 half the time).
  task automatic queue_frame(input int len, input bit bad_sum, input close_t close_kind);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] stray;
    sum   = 8'h00;
    stray = $urandom_range(1) ? SYNC_BYTE : plain_byte();
    frame_buf.push_back(SYNC_BYTE);
    frame_buf.push_back(SYNC_BYTE);
    frame_buf.push_back(len[7:0]);
    frame_buf.push_back(8'($urandom_range(255)));
    for (int i = 1; i <= len; i++) begin
      b = 8'($urandom_range(255));
      sum = sum + b;
      frame_buf.push_back(b);
    end
    if (bad_sum) begin
      b = 8'($urandom_range(1, 255));
      sum = sum + b;
    end
    frame_buf.push_back(sum);
    case (close_kind)
      CLOSE_OK: begin
        frame_buf.push_back(END_BYTE);
        frame_buf.push_back(END_BYTE);
      end
      CLOSE_BAD_FIRST: frame_buf.push_back(stray);
      default: begin
        frame_buf.push_back(END_BYTE);
        frame_buf.push_back(stray);
      end
    endcase
  endtask

  // Paired A5 inside the payload, then a second length. With overfill the new
  // length is already behind the count, so the store runs full and drops.
  task automatic queue_relength(input bit overfill);
    logic [7:0] body [DEPTH];
    logic [7:0] sum;
    int k;
    int len2;
    k = overfill ? $urandom_range(2, 8) : $urandom_range(0, 5);
    frame_buf.push_back(SYNC_BYTE);
    frame_buf.push_back(SYNC_BYTE);
    // first length leaves room past the pair, so the pair returns to the length phase
    frame_buf.push_back(8'($urandom_range(k + 1, 40)));
    for (int i = 0; i < k; i++) begin
      body[i] = plain_byte();
      frame_buf.push_back(body[i]);
    end
    body[k]     = SYNC_BYTE;
    body[k + 1] = SYNC_BYTE;
    frame_buf.push_back(SYNC_BYTE);
    frame_buf.push_back(SYNC_BYTE);
    if (overfill) begin
      frame_buf.push_back(8'($urandom_range(0, k - 1)));
      for (int i = k + 2; i <= DEPTH; i++) frame_buf.push_back(plain_byte());
    end else begin
      len2 = $urandom_range(k + 1, k + 8);
      frame_buf.push_back(len2[7:0]);
      for (int i = k + 2; i <= len2; i++) begin
        body[i] = plain_byte();
        frame_buf.push_back(body[i]);
      end
      sum = 8'h00;
      for (int i = 1; i <= len2; i++) sum = sum + body[i];
      frame_buf.push_back(sum);
      frame_buf.push_back(END_BYTE);
      frame_buf.push_back(END_BYTE);
    end
  endtask

  task automatic queue_abort();
    frame_buf.push_back(SYNC_BYTE);
    frame_buf.push_back(SYNC_BYTE);
    frame_buf.push_back(8'($urandom_range(3, 40)));
    repeat ($urandom_range(0, 3)) frame_buf.push_back(plain_byte());
    frame_buf.push_back(END_BYTE);
    frame_buf.push_back(END_BYTE);
  endtask

  // Mostly short frames; now and then a long one.
  function automatic int pick_len();
    return ($urandom_range(9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 62);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Length 0: one data word, all-ones payload byte, all-zero checksum.
  task automatic test_shortest_frame();
    frame_buf = '{SYNC_BYTE, SYNC_BYTE, 8'h00, 8'hFF, 8'h00, END_BYTE, END_BYTE};
    send_buf();
  endtask

  // First length past the limit, and the largest byte as a length.
  task automatic test_length_limits();
    frame_buf = '{SYNC_BYTE, SYNC_BYTE, 8'd63, SYNC_BYTE, SYNC_BYTE, 8'hFF};
    send_buf();
  endtask

  // Paired 5A aborts; then a paired A5 that completes the payload on its own
  // and closes with a bad checksum.
  task automatic test_marker_pairs();
    frame_buf = '{SYNC_BYTE, SYNC_BYTE, 8'd4, END_BYTE, END_BYTE,
                  SYNC_BYTE, SYNC_BYTE, 8'd0, SYNC_BYTE, SYNC_BYTE, END_BYTE, END_BYTE};
    send_buf();
  endtask

  // A5 in place of the first closing byte resumes at the second sync byte;
  // a wrong second closing byte goes back to hunting.
  task automatic test_bad_closing();
    frame_buf = '{SYNC_BYTE, SYNC_BYTE, 8'd0, 8'h00, 8'h00, SYNC_BYTE,
                  SYNC_BYTE, 8'd0, 8'h11, 8'h00, END_BYTE, 8'h00};
    send_buf();
  endtask

  // Receiver holds off while frames keep coming: the result register fills
  // and the input must stall.
  task automatic test_backpressure_fill();
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_left       = HOLD_CYCLES;
    repeat (3) queue_frame($urandom_range(3, 8), 1'b0, CLOSE_OK);
    send_buf();
    wait_idle();
  endtask

  // big: 1 starts with a full-length frame, 2 with a store overflow.
  task automatic test_random_traffic(input int idle_pct, input int stall, input int n_items,
                                     input int big);
    int target;
    int kind;
    sender_idle_pct = idle_pct;
    stall_pct       = stall;
    target          = n_sent + n_items;
    if (big == 1) queue_frame(62, 1'b0, CLOSE_OK);
    if (big == 2) queue_relength(1'b1);
    send_buf();
    while (n_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 50)      queue_frame(pick_len(), 1'b0, CLOSE_OK);
      else if (kind < 60) queue_frame(pick_len(), 1'b1, CLOSE_OK);
      else if (kind < 68) begin
        frame_buf.push_back(SYNC_BYTE);
        frame_buf.push_back(SYNC_BYTE);
        frame_buf.push_back(8'($urandom_range(63, 255)));
      end
      else if (kind < 75) queue_relength(1'b0);
      else if (kind < 80) queue_abort();
      else if (kind < 88)
        queue_frame($urandom_range(0, 6), 1'b0, $urandom_range(1) ? CLOSE_BAD_FIRST
                                                                  : CLOSE_BAD_SECOND);
      else repeat ($urandom_range(1, 6)) frame_buf.push_back(noise_byte());
      send_buf();
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_shortest_frame();
    test_length_limits();
    test_marker_pairs();
    test_bad_closing();
    wait_idle();

    test_backpressure_fill();

    test_random_traffic(0,  0,  90, 0);
    test_random_traffic(51, 0,  90, 1);
    test_random_traffic(0,  51, 90, 2);
    test_random_traffic(30, 30, 90, 1);

    if (n_errors == 0)
      $display("sync_framed_packet_deframer: match");
    else
      $display("sync_framed_packet_deframer: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("sync_framed_packet_deframer: mismatch");
    $finish;
  end

endmodule
